// File: rtl/core/bbc_pkg.sv
// Shared types, constants and decode functions for the bracket balance checker.
package bbc_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 4096;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Position counters.
  localparam int POS_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Character codes of interest.
  localparam logic [15:0] CH_LINE_FEED   = 16'h000A;
  localparam logic [15:0] CH_OPEN_ROUND  = 16'h0028;
  localparam logic [15:0] CH_CLOSE_ROUND = 16'h0029;
  localparam logic [15:0] CH_OPEN_SQUARE = 16'h005B;
  localparam logic [15:0] CH_CLOSE_SQUARE = 16'h005D;
  localparam logic [15:0] CH_OPEN_CURLY  = 16'h007B;
  localparam logic [15:0] CH_CLOSE_CURLY = 16'h007D;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EXTRA_CLOSE = 3'd1,
    ST_EXTRA_OPEN  = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Request from the checker to the stack.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    kind_t            kind;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
  } stack_cmd_t;

  // What the stack reports back.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    kind_t            top_kind;
    logic [POS_W-1:0] bottom_line;
    logic [POS_W-1:0] bottom_column;
  } stack_stat_t;

  // Kind of an opening bracket, KIND_NONE for anything else.
  function automatic kind_t open_kind(input logic [15:0] c);
    kind_t k;
    case (c)
      CH_OPEN_ROUND:  k = KIND_ROUND;
      CH_OPEN_SQUARE: k = KIND_SQUARE;
      CH_OPEN_CURLY:  k = KIND_CURLY;
      default:        k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Kind of a closing bracket, KIND_NONE for anything else.
  function automatic kind_t close_kind(input logic [15:0] c);
    kind_t k;
    case (c)
      CH_CLOSE_ROUND:  k = KIND_ROUND;
      CH_CLOSE_SQUARE: k = KIND_SQUARE;
      CH_CLOSE_CURLY:  k = KIND_CURLY;
      default:         k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/core/bbc_stack.sv
// Bracket stack: kind memory with a cached top entry and a prefetched entry below it.
module bbc_stack (
  input  logic                 clk,
  input  logic                 rst,
  input  bbc_pkg::stack_cmd_t  cmd,
  output bbc_pkg::stack_stat_t stat
);
  import bbc_pkg::*;

  kind_t            mem [STACK_DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  kind_t            top_kind;
  kind_t            below_kind;
  logic [PTR_W-1:0] rd_addr;
  logic [POS_W-1:0] bottom_line;
  logic [POS_W-1:0] bottom_column;

  // Fill level after this cycle's request.
  always_comb begin
    count_next = count;
    if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.push) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Keep the entry just below the new top ready for the next pop.
  assign rd_addr = PTR_W'(count_next - CNT_W'(2));

  // Fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Memory write at the new entry and registered prefetch read.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count[PTR_W-1:0]] <= cmd.kind;
    end
    below_kind <= mem[rd_addr];
  end

  // Cached top kind and the position of the bottom entry.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_kind <= cmd.kind;
    end else if (cmd.pop) begin
      top_kind <= below_kind;
    end
    if (cmd.push && count == '0) begin
      bottom_line   <= cmd.line;
      bottom_column <= cmd.column;
    end
  end

  assign stat.count         = count;
  assign stat.top_kind      = top_kind;
  assign stat.bottom_line   = bottom_line;
  assign stat.bottom_column = bottom_column;

  // The fill level never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack fill level above depth");

  // A clear empties the stack at the next edge.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> count == '0)
    else $error("stack not empty after clear");

  // A push is never requested on a full stack.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> count < CNT_W'(STACK_DEPTH))
    else $error("push on full stack");

endmodule

// File: rtl/core/bracket_balance_checker.sv
// Top level of the bracket balance checker: input register, checker logic and result buffer.
//
// Streams a text one character per transfer, closed by a transfer with is_end set, and
// checks that round, square and curly brackets nest and match. The block takes one
// transfer per clock cycle while the skid entry is free. The input register takes a
// transfer, and the result register, or the skid entry behind it, takes the verdict.
// A two-entry result buffer lets the input keep flowing while a result waits. Without
// result stalls, the sustained rate of one character per cycle is set by the stack,
// which caches its top kind in a register and prefetches the entry below
// from its memory, so pushes and pops may follow each other in every cycle. A failure
// (extra closing bracket or stack overflow) is reported at once with its line and column;
// the rest of the text up to the end marker is then ignored and that end marker gives no
// result. Any other end marker gives success, empty text, or an extra opening bracket at
// the position of the outermost open bracket. Line and column saturate at 65535. The
// stack memory needs no clearing after reset.
module bracket_balance_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [15:0] char_code,
  input  logic        is_end,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [15:0] line,
  output logic [15:0] column
);
  import bbc_pkg::*;

  // Input register.
  logic        s1_valid;
  logic [15:0] s1_char;
  logic        s1_end;
  logic        s1_fire;
  logic        in_take;

  // Text state.
  logic [POS_W-1:0] line_count;
  logic [POS_W-1:0] line_count_next;
  logic [POS_W-1:0] column_count;
  logic [POS_W-1:0] column_count_next;
  logic [POS_W-1:0] column_inc;
  logic             failed_latch;
  logic             failed_latch_next;
  logic             seen_character;
  logic             seen_character_next;

  // Stack interface.
  stack_cmd_t  cmd;
  stack_stat_t stat;
  kind_t       ok_kind;
  kind_t       ck_kind;

  // Result of the current item.
  logic             res_valid;
  status_t          res_status;
  logic [POS_W-1:0] res_line;
  logic [POS_W-1:0] res_column;

  // Skid entry behind the result register.
  logic             skid_valid;
  status_t          skid_status;
  logic [POS_W-1:0] skid_line;
  logic [POS_W-1:0] skid_column;
  logic             out_take;

  // The checker stage runs whenever the skid entry is free.
  assign s1_fire    = s1_valid && !skid_valid;
  assign item_stall = s1_valid && skid_valid;
  assign in_take    = item_valid && !item_stall;
  assign out_take   = result_valid && !result_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
      s1_char  <= char_code;
      s1_end   <= is_end;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  bbc_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  assign ok_kind    = open_kind(s1_char);
  assign ck_kind    = close_kind(s1_char);
  assign column_inc = (column_count == POS_MAX) ? column_count : column_count + POS_W'(1);

  // Checker logic for one item.
  always_comb begin
    line_count_next     = line_count;
    column_count_next   = column_count;
    failed_latch_next   = failed_latch;
    seen_character_next = seen_character;
    cmd                 = '0;
    res_valid           = 1'b0;
    res_status          = ST_OK;
    res_line            = '0;
    res_column          = '0;
    if (s1_fire) begin
      if (s1_end) begin
        // End of text: report unless the text failed, and return to the reset state.
        if (!failed_latch) begin
          res_valid = 1'b1;
          if (!seen_character) begin
            res_status = ST_EMPTY;
          end else if (stat.count == '0) begin
            res_status = ST_OK;
          end else begin
            res_status = ST_EXTRA_OPEN;
            res_line   = stat.bottom_line;
            res_column = stat.bottom_column;
          end
        end
        cmd.clear           = 1'b1;
        line_count_next     = POS_W'(1);
        column_count_next   = '0;
        failed_latch_next   = 1'b0;
        seen_character_next = 1'b0;
      end else begin
        seen_character_next = 1'b1;
        if (!failed_latch) begin
          if (s1_char == CH_LINE_FEED) begin
            if (line_count != POS_MAX) begin
              line_count_next = line_count + POS_W'(1);
            end
            column_count_next = '0;
          end else begin
            column_count_next = column_inc;
            if (ok_kind != KIND_NONE) begin
              // Opening bracket: push, or flag overflow on a full stack.
              if (stat.count == CNT_W'(STACK_DEPTH)) begin
                failed_latch_next = 1'b1;
                res_valid         = 1'b1;
                res_status        = ST_OVERFLOW;
                res_line          = line_count;
                res_column        = column_inc;
              end else begin
                cmd.push   = 1'b1;
                cmd.kind   = ok_kind;
                cmd.line   = line_count;
                cmd.column = column_inc;
              end
            end else if (ck_kind != KIND_NONE) begin
              // Closing bracket: must meet an open bracket of the same kind.
              if (stat.count == '0 || stat.top_kind != ck_kind) begin
                failed_latch_next = 1'b1;
                res_valid         = 1'b1;
                res_status        = ST_EXTRA_CLOSE;
                res_line          = line_count;
                res_column        = column_inc;
              end else begin
                cmd.pop = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // Text state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count     <= POS_W'(1);
      column_count   <= '0;
      failed_latch   <= 1'b0;
      seen_character <= 1'b0;
    end else begin
      line_count     <= line_count_next;
      column_count   <= column_count_next;
      failed_latch   <= failed_latch_next;
      seen_character <= seen_character_next;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || out_take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        status       <= skid_status;
        line         <= skid_line;
        column       <= skid_column;
        skid_valid   <= 1'b0;
      end else if (res_valid) begin
        result_valid <= 1'b1;
        status       <= res_status;
        line         <= res_line;
        column       <= res_column;
      end else begin
        result_valid <= 1'b0;
      end
    end else if (res_valid) begin
      skid_valid  <= 1'b1;
      skid_status <= res_status;
      skid_line   <= res_line;
      skid_column <= res_column;
    end
  end

  // The skid entry only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held without a result in the output register");

  // A reported failure silences the rest of the text.
  a_fail_latches: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_EXTRA_CLOSE || res_status == ST_OVERFLOW)
    |=> failed_latch)
    else $error("failure reported without setting the failed latch");

  // An end marker returns the text state to its start values.
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_end |=> !seen_character && !failed_latch && line_count == POS_W'(1)
      && column_count == '0)
    else $error("text state not restarted after end marker");

  // No result is produced after a failure, before the end marker.
  a_quiet_after_fail: assert property (@(posedge clk) disable iff (rst)
    failed_latch |-> !res_valid)
    else $error("result produced after a failure");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the bracket balance checker: stimulus, prediction and checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  // One verdict the checker is expected to report.
  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
  } verdict_t;

  // One open bracket held by the predictor.
  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
  } open_bracket_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [15:0] char_code;
  logic        is_end;
  logic        result_valid;
  logic        result_stall;
  logic [2:0]  status;
  logic [15:0] line;
  logic [15:0] column;

  // Predictor state for the text in flight.
  open_bracket_t    open_brackets [STACK_DEPTH];
  int unsigned      open_depth;
  logic [POS_W-1:0] cur_line;
  logic [POS_W-1:0] cur_column;
  bit               text_failed;
  bit               text_started;
  verdict_t         pending_verdicts [$];

  // Pacing of both sides and run statistics.
  int          tx_gap_max;
  int          rx_gap_max;
  int          hold_request;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned counted_items;
  int unsigned verdicts_checked;
  int unsigned input_held_cycles;

  bracket_balance_checker dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .char_code    (char_code),
    .is_end       (is_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .line         (line),
    .column       (column)
  );

  // Free-running clock, 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Guard against a hung run.
  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Prints one mismatch line (up to a cap) and counts it.
  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic logic [15:0] opener_of(input kind_t k);
    case (k)
      KIND_ROUND:  return CH_OPEN_ROUND;
      KIND_SQUARE: return CH_OPEN_SQUARE;
      default:     return CH_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [15:0] closer_of(input kind_t k);
    case (k)
      KIND_ROUND:  return CH_CLOSE_ROUND;
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      default:     return CH_CLOSE_CURLY;
    endcase
  endfunction

  // Any character that is neither a bracket nor a line feed.
  function automatic logic [15:0] plain_char();
    logic [15:0] c;
    c = 16'($urandom_range(0, 65535));
    while (c == CH_LINE_FEED || c == CH_OPEN_ROUND || c == CH_CLOSE_ROUND ||
           c == CH_OPEN_SQUARE || c == CH_CLOSE_SQUARE ||
           c == CH_OPEN_CURLY || c == CH_CLOSE_CURLY) begin
      c = 16'($urandom_range(0, 65535));
    end
    return c;
  endfunction

  function automatic void note_verdict(input status_t s, input logic [POS_W-1:0] ln,
                                       input logic [POS_W-1:0] col);
    verdict_t v;
    v.status = s;
    v.line   = ln;
    v.column = col;
    pending_verdicts.push_back(v);
  endfunction

  // Advances the predicted checker state by one accepted transfer.
  task automatic balance_step(input logic [15:0] c, input logic e);
    bit    opening;
    kind_t k;
    opening = 1'b0;
    k = KIND_NONE;
    case (c)
      CH_OPEN_ROUND:   begin opening = 1'b1; k = KIND_ROUND; end
      CH_OPEN_SQUARE:  begin opening = 1'b1; k = KIND_SQUARE; end
      CH_OPEN_CURLY:   begin opening = 1'b1; k = KIND_CURLY; end
      CH_CLOSE_ROUND:  k = KIND_ROUND;
      CH_CLOSE_SQUARE: k = KIND_SQUARE;
      CH_CLOSE_CURLY:  k = KIND_CURLY;
      default: ;
    endcase

    if (e) begin
      // End marker: a verdict unless the text already failed, then a fresh start.
      if (!text_failed) begin
        counted_items++;
        if (!text_started) begin
          note_verdict(ST_EMPTY, '0, '0);
        end else if (open_depth == 0) begin
          note_verdict(ST_OK, '0, '0);
        end else begin
          note_verdict(ST_EXTRA_OPEN, open_brackets[0].line, open_brackets[0].column);
        end
      end
      open_depth   = 0;
      cur_line     = POS_W'(1);
      cur_column   = '0;
      text_failed  = 1'b0;
      text_started = 1'b0;
    end else begin
      text_started = 1'b1;
      if (!text_failed) begin
        counted_items++;
        if (c == CH_LINE_FEED) begin
          if (cur_line != POS_MAX) cur_line++;
          cur_column = '0;
        end else begin
          if (cur_column != POS_MAX) cur_column++;
          if (opening) begin
            // A full stack rejects the bracket and fails the text.
            if (open_depth == STACK_DEPTH) begin
              text_failed = 1'b1;
              note_verdict(ST_OVERFLOW, cur_line, cur_column);
            end else begin
              open_brackets[open_depth] = '{k, cur_line, cur_column};
              open_depth++;
            end
          end else if (k != KIND_NONE) begin
            // A closing bracket must meet an open bracket of its own kind.
            if (open_depth == 0 || open_brackets[open_depth - 1].kind != k) begin
              text_failed = 1'b1;
              note_verdict(ST_EXTRA_CLOSE, cur_line, cur_column);
            end else begin
              open_depth--;
            end
          end
        end
      end
    end
  endtask

  // Offers one transfer after a random gap and holds it until it is taken.
  task automatic send_item(input logic [15:0] c, input logic e);
    int gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      item_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid = 1'b1;
    char_code  = c;
    is_end     = e;
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
    items_sent++;
    balance_step(c, e);
  endtask

  // Result side: pacing of result_stall and the check of every result transfer.
  initial begin : result_side
    verdict_t want;
    int       rx_wait;
    bit       rx_drawn;
    int       hold_left;
    rx_wait      = 0;
    rx_drawn     = 1'b0;
    hold_left    = 0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (item_valid && item_stall) input_held_cycles++;
        if (result_valid && !result_stall) begin
          rx_drawn = 1'b0;
          if (pending_verdicts.size() == 0) begin
            flag_mismatch($sformatf("unexpected result status %0d line %0d column %0d",
                                    status, line, column));
          end else begin
            want = pending_verdicts.pop_front();
            verdicts_checked++;
            if (status !== want.status)
              flag_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
            if (line !== want.line)
              flag_mismatch($sformatf("line %0d, predicted %0d", line, want.line));
            if (column !== want.column)
              flag_mismatch($sformatf("column %0d, predicted %0d", column, want.column));
          end
        end
      end
      @(negedge clk);
      // A long hold-off requested by a test is counted down here.
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (result_valid && !rx_drawn) begin
        rx_wait  = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
        rx_drawn = 1'b1;
      end
      if (hold_left > 0) begin
        result_stall = 1'b1;
        hold_left--;
      end else if (rx_wait > 0) begin
        result_stall = 1'b1;
        rx_wait--;
      end else begin
        result_stall = 1'b0;
      end
    end
  end

  // Short texts for each verdict but overflow, extreme character codes and the ignore-after-failure rule.
  task automatic test_directed_cases();
    tx_gap_max = 6;
    rx_gap_max = 6;
    // Empty text; the code carried with the end marker is ignored.
    send_item(16'hFFFF, 1'b1);
    // All three kinds nested and closed.
    send_item(CH_OPEN_ROUND, 1'b0);
    send_item(CH_OPEN_SQUARE, 1'b0);
    send_item(CH_OPEN_CURLY, 1'b0);
    send_item(CH_CLOSE_CURLY, 1'b0);
    send_item(CH_CLOSE_SQUARE, 1'b0);
    send_item(CH_CLOSE_ROUND, 1'b0);
    send_item(16'h0000, 1'b1);
    // Unclosed bracket on the second line, after a line feed.
    send_item(CH_LINE_FEED, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(CH_OPEN_ROUND, 1'b0);
    send_item(16'h0000, 1'b1);
    // Wrong kind; the rest of the text and its end marker give nothing.
    send_item(CH_OPEN_ROUND, 1'b0);
    send_item(CH_CLOSE_SQUARE, 1'b0);
    send_item(CH_OPEN_ROUND, 1'b0);
    send_item(16'hFFFF, 1'b1);
    // Closing bracket with nothing open.
    send_item(CH_CLOSE_ROUND, 1'b0);
    send_item(16'h0000, 1'b1);
    send_item(16'h0000, 1'b0);
    send_item(CH_CLOSE_CURLY, 1'b0);
    send_item(16'h0000, 1'b1);
    // A text of only a line feed is balanced, not empty.
    send_item(CH_LINE_FEED, 1'b0);
    send_item(16'h5555, 1'b1);
  endtask

  // Fills the stack to its depth and unwinds it, then overflows it by one.
  task automatic test_stack_limits();
    kind_t filled [$];
    kind_t k;
    tx_gap_max = 0;
    rx_gap_max = 6;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      k = kind_t'($urandom_range(0, 2));
      filled.push_back(k);
      send_item(opener_of(k), 1'b0);
    end
    while (filled.size() > 0) send_item(closer_of(filled.pop_back()), 1'b0);
    send_item(16'h0000, 1'b1);
    for (int i = 0; i < STACK_DEPTH; i++) send_item(CH_OPEN_CURLY, 1'b0);
    send_item(CH_OPEN_SQUARE, 1'b0);
    send_item(CH_CLOSE_SQUARE, 1'b0);
    send_item(16'h0000, 1'b1);
  endtask

  // Drives column and line counters past their saturation point.
  task automatic test_counter_saturation();
    tx_gap_max = 0;
    rx_gap_max = 6;
    repeat (int'(POS_MAX) + 40) send_item(plain_char(), 1'b0);
    send_item(CH_OPEN_SQUARE, 1'b0);
    send_item(16'hFFFF, 1'b1);
    repeat (int'(POS_MAX) + 40) send_item(CH_LINE_FEED, 1'b0);
    send_item(plain_char(), 1'b0);
    send_item(CH_OPEN_ROUND, 1'b0);
    send_item(CH_CLOSE_SQUARE, 1'b0);
    send_item(16'h0000, 1'b1);
  endtask

  // Blocks the result side for a long stretch while short texts keep coming.
  task automatic test_result_backpressure();
    tx_gap_max   = 0;
    rx_gap_max   = 0;
    hold_request = 300;
    repeat (40) begin
      send_item(plain_char(), 1'b0);
      send_item(16'($urandom_range(0, 65535)), 1'b1);
    end
  endtask

  // One random text: mostly well formed, some broken, some pure noise.
  task automatic send_random_text();
    kind_t open_kinds [$];
    kind_t k;
    int    flavor;
    int    len;
    int    r;
    flavor = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 40);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      k = kind_t'($urandom_range(0, 2));
      if (flavor >= 88) begin
        if (r < 50) send_item(16'($urandom_range(0, 65535)), 1'b0);
        else if (r < 65) send_item(CH_LINE_FEED, 1'b0);
        else if (r < 83) send_item(opener_of(k), 1'b0);
        else send_item(closer_of(k), 1'b0);
      end else if (flavor >= 70 && r < 4) begin
        // Stray closing bracket of any kind breaks the nesting.
        send_item(closer_of(k), 1'b0);
      end else if (r < 30) begin
        open_kinds.push_back(k);
        send_item(opener_of(k), 1'b0);
      end else if (r < 55 && open_kinds.size() > 0) begin
        send_item(closer_of(open_kinds.pop_back()), 1'b0);
      end else if (r < 62) begin
        send_item(CH_LINE_FEED, 1'b0);
      end else begin
        send_item(plain_char(), 1'b0);
      end
    end
    // Most well-formed texts are closed completely before the end marker.
    if (flavor < 70 && $urandom_range(0, 9) < 7) begin
      while (open_kinds.size() > 0) send_item(closer_of(open_kinds.pop_back()), 1'b0);
    end
    send_item(16'($urandom_range(0, 65535)), 1'b1);
  endtask

  // Random texts until enough transfers outside failed text tails have been counted.
  task automatic test_random_texts();
    int unsigned start_count;
    start_count = counted_items;
    while (counted_items - start_count < 1650) begin
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      send_random_text();
    end
  endtask

  // Reset, the tests in turn, drain and verdict.
  initial begin
    rst               = 1'b1;
    item_valid        = 1'b0;
    char_code         = 16'h0000;
    is_end            = 1'b0;
    tx_gap_max        = 0;
    rx_gap_max        = 0;
    hold_request      = 0;
    error_count       = 0;
    items_sent        = 0;
    counted_items     = 0;
    verdicts_checked  = 0;
    input_held_cycles = 0;
    open_depth        = 0;
    cur_line          = POS_W'(1);
    cur_column        = '0;
    text_failed       = 1'b0;
    text_started      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_stack_limits();
    test_counter_saturation();
    test_result_backpressure();
    test_random_texts();

    @(negedge clk);
    item_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d transfers; %0d verdicts checked across empty, balanced, unclosed,",
             items_sent, verdicts_checked);
    $display("stray-closing, overflow and saturated-position texts; input held %0d cycles.",
             input_held_cycles);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
